// ----- rtl/core/binary_search_engine_defines.svh -----
// Assertion helpers used by the checker file bse_checker.sv.
`ifndef BINARY_SEARCH_ENGINE_DEFINES_SVH
`define BINARY_SEARCH_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BSE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/bse_pkg.sv -----
package bse_pkg;

	// Field widths of the block's channels
	localparam int SIZE_W  = 11;
	localparam int INDEX_W = 10;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 4;

	localparam int DEPTH_DEFAULT = 1024;

	// Request codes
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic load;   // write one table entry
		logic start;  // set up a search and issue the first read
		logic probe;  // compare, narrow bounds, issue next read
	} bse_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;  // search range is empty at start
		logic hit;    // probed entry equals key
		logic more;   // bounds still open after this probe
	} bse_stat_t;

endpackage

// ----- rtl/core/bse_datapath.sv -----
module bse_datapath #(
	parameter int TABLE_DEPTH = bse_pkg::DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bse_pkg::bse_cmd_t                  cmd,
	output bse_pkg::bse_stat_t                 stat,
	input  logic                               cfg_we,
	input  logic [bse_pkg::SIZE_W-1:0]         cfg_data,
	input  logic [bse_pkg::INDEX_W-1:0]        load_index,
	input  logic signed [bse_pkg::VALUE_W-1:0] item_value,
	output logic                               found,
	output logic [bse_pkg::COUNT_W-1:0]        probe_count
);
	import bse_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int NW = AW + 1;

	logic [SIZE_W-1:0]         tsize_q;
	logic signed [VALUE_W-1:0] key_q;
	logic signed [VALUE_W-1:0] rd_q;
	logic [NW-1:0]             lo_q;
	logic [NW-1:0]             hi1_q;   // exclusive upper bound
	logic [NW-1:0]             mid_q;
	logic [COUNT_W-1:0]        cnt_q;
	logic                      found_q;
	logic [COUNT_W-1:0]        count_q;
	logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];

	logic [NW-1:0] n_sat;
	logic [NW-1:0] mid0;
	logic [NW-1:0] mid_lo;   // next midpoint when key is below entry
	logic [NW-1:0] mid_hi;   // next midpoint when key is above entry
	logic [NW-1:0] mid_p1;
	logic          cont_lo;
	logic          cont_hi;
	logic          hit;
	logic          lt;
	logic          more;
	logic [NW-1:0] mid_nx;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_ok;

	// Search size, clipped to the table depth
	assign n_sat = (32'(tsize_q) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(tsize_q);
	assign mid0  = NW'(({1'b0, n_sat} - (NW+1)'(1)) >> 1);

	// Both possible next bounds, worked out alongside the compare
	assign mid_p1  = mid_q + NW'(1);
	assign mid_lo  = NW'((({1'b0, lo_q} + {1'b0, mid_q}) - (NW+1)'(1)) >> 1);
	assign mid_hi  = NW'(({1'b0, mid_q} + {1'b0, hi1_q}) >> 1);
	assign cont_lo = lo_q < mid_q;
	assign cont_hi = mid_p1 < hi1_q;

	assign hit  = (rd_q == key_q);
	assign lt   = (key_q < rd_q);
	assign more = lt ? cont_lo : cont_hi;

	assign stat.empty = (n_sat == '0);
	assign stat.hit   = hit;
	assign stat.more  = more;

	// Read port address and enable
	assign mid_nx  = cmd.start ? mid0 : (lt ? mid_lo : mid_hi);
	assign rd_addr = mid_nx[AW-1:0];
	assign rd_en   = (cmd.start && !stat.empty) || (cmd.probe && !hit && more);
	assign wr_ok   = 32'(load_index) < 32'(TABLE_DEPTH);

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load && wr_ok) begin
			mem[AW'(load_index)] <= item_value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q <= '0;
		end else if (cfg_we) begin
			tsize_q <= cfg_data;
		end
	end

	// Search bounds, key and probe counter
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= item_value;
			lo_q  <= '0;
			hi1_q <= n_sat;
			mid_q <= mid0;
			cnt_q <= '0;
		end else if (cmd.probe) begin
			cnt_q <= cnt_q + COUNT_W'(1);
			mid_q <= mid_nx;
			if (lt) begin
				hi1_q <= mid_q;
			end else begin
				lo_q <= mid_p1;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.start && stat.empty) begin
			found_q <= 1'b0;
			count_q <= '0;
		end else if (cmd.probe && (hit || !more)) begin
			found_q <= hit;
			count_q <= cnt_q + COUNT_W'(1);
		end
	end

	assign found       = found_q;
	assign probe_count = count_q;

endmodule

// ----- rtl/core/bse_ctrl.sv -----
module bse_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	output logic               out_valid,
	input  logic               out_ready,
	input  bse_pkg::bse_stat_t stat,
	output bse_pkg::bse_cmd_t  cmd
);
	import bse_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_PROBE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_fire;
	logic   slot_free;
	logic   res_done;

	// A search starts only when the result register is free or emptying
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && ((req_type == REQ_LOAD) || slot_free);
	assign in_fire   = in_valid && in_ready;

	assign cmd.load  = in_fire && (req_type == REQ_LOAD);
	assign cmd.start = in_fire && (req_type == REQ_SEARCH);
	assign cmd.probe = (state_q == ST_PROBE);

	// Result lands: empty search at start, or last probe of a search
	assign res_done = ((state_q == ST_IDLE) && cmd.start && stat.empty) ||
		((state_q == ST_PROBE) && (stat.hit || !stat.more));

	assign out_valid = out_valid_q;

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (res_done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.start && !stat.empty) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (res_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/binary_search_engine.sv -----
// Load beat: taken while the controller is idle, no result.
// Search beat: set up the bounds and issue the first read, then probe until a hit or until the
// bounds close, and the result registers; an empty range registers a miss with zero probes.
// The single registered read port of the table sets one probe per cycle.
// Reset clears the control state and table_size; table contents are undefined until loaded.
module binary_search_engine #(
	parameter int TABLE_DEPTH = bse_pkg::DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bse_pkg::SIZE_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               req_type,
	input  logic [bse_pkg::INDEX_W-1:0]        load_index,
	input  logic signed [bse_pkg::VALUE_W-1:0] item_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               found,
	output logic [bse_pkg::COUNT_W-1:0]        probe_count
);
	import bse_pkg::*;

	bse_cmd_t  cmd;
	bse_stat_t stat;

	// Configuration is always taken
	assign cfg_ready = 1'b1;

	bse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bse_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.load_index  (load_index),
		.item_value  (item_value),
		.found       (found),
		.probe_count (probe_count)
	);

endmodule

// ----- rtl/core/bse_checker.sv -----
`include "binary_search_engine_defines.svh"

module bse_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               req_type,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               found,
	input logic [bse_pkg::COUNT_W-1:0]        probe_count
);
	import bse_pkg::*;

	// A stalled result holds
	`BSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(found) && $stable(probe_count), "result changed while stalled")

	// A hit always took at least one probe
	`BSE_ASSERT_NOW(a_hit_probed, out_valid && found, probe_count != '0, "hit reported with zero probes")

	// A load never raises a result
	`BSE_ASSERT_NEXT(a_load_silent, in_valid && in_ready && (req_type == REQ_LOAD) && !out_valid, !out_valid, "load produced a result")

	// A search is only taken when the result slot can receive it
	`BSE_ASSERT_NOW(a_search_slot, in_valid && in_ready && (req_type == REQ_SEARCH), !out_valid || out_ready, "search taken with result slot full")

endmodule

bind binary_search_engine bse_checker u_bse_checker (.*);

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import bse_pkg::*;

	localparam int DEPTH         = DEPTH_DEFAULT;
	localparam int SIZE_MAX      = (1 << SIZE_W) - 1;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int ITEM_TARGET   = 1600;
	localparam int PHASE_ITEMS   = 40;

	localparam logic signed [VALUE_W-1:0] MIN32 = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] MAX32 = 32'sh7FFF_FFFF;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic               found;
		logic [COUNT_W-1:0] probes;
	} search_result_t;

	// Shadow table, search predictor and in-order result store
	class search_scoreboard;
		logic signed [VALUE_W-1:0] entries [DEPTH];
		int                        table_size;
		search_result_t            pending_results [$];
		int                        errors;

		function new();
			table_size = 0;
			errors = 0;
		endfunction

		function void set_size(logic [SIZE_W-1:0] size);
			table_size = size;
		endfunction

		// Accepted input beat: loads update the shadow, searches queue a prediction
		function void note_item(logic req, logic [INDEX_W-1:0] idx,
				logic signed [VALUE_W-1:0] val);
			search_result_t res;
			int lo, hi, mid, n, count;
			if (req == REQ_LOAD) begin
				entries[idx] = val;
				return;
			end
			n = (table_size > DEPTH) ? DEPTH : table_size;
			lo = 0;
			hi = n - 1;
			count = 0;
			res.found = 1'b0;
			// inclusive bounds, floor midpoint, stop on first equal entry
			while (lo <= hi && !res.found) begin
				mid = (lo + hi) / 2;
				count++;
				if (entries[mid] == val) res.found = 1'b1;
				else if (val < entries[mid]) hi = mid - 1;
				else lo = mid + 1;
			end
			res.probes = count[COUNT_W-1:0];
			pending_results.push_back(res);
		endfunction

		// Accepted output beat: compare against the oldest prediction
		function void check_result(logic found, logic [COUNT_W-1:0] probes);
			search_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: found=%0b probes=%0d", found, probes);
				return;
			end
			want = pending_results.pop_front();
			if (want.found !== found || want.probes !== probes) begin
				errors++;
				if (errors <= 10)
					$display("result mismatch: expected found=%0b probes=%0d, got found=%0b probes=%0d",
						want.found, want.probes, found, probes);
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n      = 1'b0;
	logic                        cfg_valid   = 1'b0;
	logic                        cfg_ready;
	logic [SIZE_W-1:0]           cfg_data    = '0;
	logic                        in_valid    = 1'b0;
	logic                        in_ready;
	logic                        req_type    = REQ_LOAD;
	logic [INDEX_W-1:0]          load_index  = '0;
	logic signed [VALUE_W-1:0]   item_value  = '0;
	logic                        out_valid;
	logic                        out_ready   = 1'b0;
	logic                        found;
	logic [COUNT_W-1:0]          probe_count;

	search_scoreboard sb = new();
	idle_mode_t       idle_mode = IDLE_NONE;
	int               hold_req = 0;
	int               items_sent = 0;

	binary_search_engine dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.load_index  (load_index),
		.item_value  (item_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.probe_count (probe_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drive one input beat, with an optional random gap in front of it
	task automatic send_item(logic req, int unsigned idx, logic signed [VALUE_W-1:0] val);
		int gap;
		gap = 0;
		if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
			while ($urandom_range(99) < ((idle_mode == IDLE_SENDER) ? 85 : 14)) gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= req;
		load_index <= idx[INDEX_W-1:0];
		item_value <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(req, idx[INDEX_W-1:0], val);
		items_sent++;
	endtask

	// Sender pause until every predicted result is back, plus tail for a trailing load
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// table_size write, only with the block idle
	task automatic write_size(int unsigned size);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= size[SIZE_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_size(size[SIZE_W-1:0]);
	endtask

	// Load entries 0..n-1 in ascending order; some steps repeat a value
	task automatic load_sorted(int n, longint start, int unsigned spread);
		longint v;
		v = start;
		for (int i = 0; i < n; i++) begin
			if (v > longint'(MAX32)) v = longint'(MAX32);
			send_item(REQ_LOAD, i, v[VALUE_W-1:0]);
			if ($urandom_range(15) != 0) v += $urandom_range(spread);
		end
	endtask

	// Mostly keys present in the searched range, some neighbors, some anything
	function automatic logic signed [VALUE_W-1:0] pick_key(int size);
		logic signed [VALUE_W-1:0] key;
		int span;
		span = (size > DEPTH) ? DEPTH : size;
		key = $urandom;
		if (span > 0 && $urandom_range(9) < 8) begin
			key = sb.entries[$urandom_range(span - 1)];
			if ($urandom_range(3) == 0) key = key + ($urandom_range(1) ? 1 : -1);
		end
		return key;
	endfunction

	// Receiver: check accepted results, stall at random or for a long hold-off
	initial begin
		int hold_left, hold_seen, pct;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) sb.check_result(found, probe_count);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			pct = (idle_mode == IDLE_RECEIVER) ? 85 : (idle_mode == IDLE_BOTH) ? 14 : 0;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= pct);
			end
		end
	end

	// Stimulus
	initial begin
		int phase, size, roll;
		longint start;
		phase = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: no probes
		send_item(REQ_SEARCH, 0, MIN32);
		send_item(REQ_SEARCH, DEPTH - 1, MAX32);
		send_item(REQ_SEARCH, 0, 0);

		// small ordered table holding both value extremes
		send_item(REQ_LOAD, 0, MIN32);
		send_item(REQ_LOAD, 1, -5);
		send_item(REQ_LOAD, 2, 7);
		send_item(REQ_LOAD, 3, MAX32);
		write_size(1);
		send_item(REQ_SEARCH, 0, MIN32);
		send_item(REQ_SEARCH, 0, MAX32);
		write_size(4);
		send_item(REQ_SEARCH, 0, MIN32);
		send_item(REQ_SEARCH, 0, -5);
		send_item(REQ_SEARCH, 0, 7);
		send_item(REQ_SEARCH, 0, MAX32);
		send_item(REQ_SEARCH, 0, 0);
		send_item(REQ_SEARCH, 0, MIN32 + 1);
		send_item(REQ_SEARCH, 0, MAX32 - 1);

		// unordered table: the fixed probe path misses a present key
		send_item(REQ_LOAD, 2, -100);
		send_item(REQ_SEARCH, 0, -100);
		send_item(REQ_SEARCH, 0, MAX32);

		// whole table loaded in ascending order over the full value range
		load_sorted(DEPTH, longint'(MIN32), 8_400_000);
		write_size(DEPTH);
		for (int i = 0; i < PHASE_ITEMS; i++) send_item(REQ_SEARCH, 0, pick_key(DEPTH));

		// oversized table_size, with a long receiver hold-off to back up the input
		write_size(SIZE_MAX);
		hold_req++;
		for (int i = 0; i < PHASE_ITEMS; i++) send_item(REQ_SEARCH, 0, pick_key(DEPTH));

		// random phases, each with its own size and idling mode
		while (items_sent < ITEM_TARGET) begin
			idle_mode = idle_mode_t'(phase % 4);
			case ($urandom_range(7))
				0: size = DEPTH;
				1: size = $urandom_range(DEPTH + 1, SIZE_MAX);
				2: size = $urandom_range(41, DEPTH - 1);
				3: size = $urandom_range(0, 2);
				default: size = $urandom_range(1, 40);
			endcase
			if (size <= 40 && $urandom_range(3) != 0) begin
				start = $urandom_range(1) ? longint'(MIN32) : longint'($signed($urandom));
				load_sorted(size, start, $urandom_range(1) ? 3 : 100_000);
			end
			write_size(size);
			if (phase % 5 == 3) hold_req++;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				roll = $urandom_range(99);
				if (roll < 8) begin
					// stray load anywhere, may break the ordering
					send_item(REQ_LOAD, $urandom_range(DEPTH - 1), $urandom);
				end else begin
					if (roll < 11) wait_drained();
					send_item(REQ_SEARCH, $urandom_range(DEPTH - 1), pick_key(size));
				end
			end
			phase++;
		end

		wait_drained();
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/bse_pkg.sv
rtl/core/bse_datapath.sv
rtl/core/bse_ctrl.sv
rtl/core/binary_search_engine.sv
rtl/core/bse_checker.sv
dv/testbench.sv
